// File: design/nfa_wr_pkg.sv
// Package for the NFA word recognizer: sizes, request codes, register map.
// Used by nfa_word_recognizer_top; depends on nothing.
`default_nettype none

package nfa_wr_pkg;

	localparam int NUM_STATES   = 32;
	localparam int LETTER_COUNT = 256;
	localparam int LETTER_W     = $clog2(LETTER_COUNT);
	localparam int ROW_W        = NUM_STATES * NUM_STATES;
	localparam int ROW_IDX_W    = $clog2(ROW_W);

	localparam int IN_W  = 24;
	localparam int OUT_W = 40;
	localparam int ADDR_W = 3;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_START  = 2'd1;
	localparam logic [1:0] REQ_SYMBOL = 2'd2;

	localparam logic REG_INITIAL = 1'b0;
	localparam logic REG_FINAL   = 1'b1;

	typedef logic [NUM_STATES-1:0] state_set_t;
	typedef logic [ROW_W-1:0]      row_t;

endpackage

`default_nettype wire

// File: design/nfa_word_recognizer_top.sv
// NFA word recognizer: stream input of requests, stream output of active sets.
// Depends on nfa_wr_pkg. One row memory indexed by letter holds all successor masks.
//
// Usage:
//   s_tdata carries one request word: add a transition, start a word, or
//   consume a symbol. Every accepted word gives exactly one result word on
//   m_tdata: the active state set after the request and the accept flag.
//   initial_states and final_states are written through the APB port; the user
//   must do so only while no request is in flight, as the block does not enforce it.
// Timing:
//   On acceptance the letter's row is read from the transition memory into a
//   register; the execute state then merges and writes back the row or updates
//   the active set, and registers the result in the output register. A new
//   request is taken only after the current one has left the execute state,
//   as the row memory is read on acceptance and written back on completion.
// Stall:
//   A result held by a stalled receiver sits in the output register; the
//   next request may still be accepted and waits in its execute cycle until
//   the output register frees up.
// Reset:
//   arst_n clears the active set, both registers and the row valid bits, so
//   every letter starts with no transitions. No clearing pass is needed.
`default_nettype none

module nfa_word_recognizer_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// APB configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [nfa_wr_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	// request stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// s_tdata: req_type[1:0], from_state[6:2], letter[14:7], to_state[19:15], zero pad
	input  wire logic [nfa_wr_pkg::IN_W-1:0]   s_tdata,
	// result stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// m_tdata: active_set[31:0], accepted[32], zero pad
	output logic      [nfa_wr_pkg::OUT_W-1:0]  m_tdata
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic st_q;

	nfa_wr_pkg::state_set_t initial_q;
	nfa_wr_pkg::state_set_t final_q;
	nfa_wr_pkg::state_set_t active_q;

	logic [1:0] req_s1;
	logic [4:0] from_s1;
	logic [7:0] letter_s1;
	logic [4:0] to_s1;

	nfa_wr_pkg::row_t mem [nfa_wr_pkg::LETTER_COUNT];
	nfa_wr_pkg::row_t rdata_s1;
	logic [nfa_wr_pkg::LETTER_COUNT-1:0] row_valid_q;
	logic row_valid_s1;

	logic out_valid_q;
	nfa_wr_pkg::state_set_t out_set_q;
	logic out_acc_q;

	logic accept_in;
	logic complete;
	logic cfg_write;
	logic add_ok;
	logic letter_ok;
	nfa_wr_pkg::row_t row_cur;
	nfa_wr_pkg::row_t row_new;
	logic [nfa_wr_pkg::ROW_IDX_W-1:0] bit_idx;
	nfa_wr_pkg::state_set_t succ;
	nfa_wr_pkg::state_set_t active_next;
	logic [nfa_wr_pkg::LETTER_W-1:0] in_row;
	logic [nfa_wr_pkg::LETTER_W-1:0] cur_row;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;

	always_comb begin
		case (paddr[2])
			nfa_wr_pkg::REG_INITIAL: prdata = 32'(initial_q);
			nfa_wr_pkg::REG_FINAL:   prdata = 32'(final_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_q <= '0;
			final_q   <= '0;
		end else if (cfg_write) begin
			if (paddr[2] == nfa_wr_pkg::REG_INITIAL) begin
				initial_q <= nfa_wr_pkg::NUM_STATES'(pwdata);
			end else begin
				final_q <= nfa_wr_pkg::NUM_STATES'(pwdata);
			end
		end
	end

	assign s_tready  = (st_q == ST_IDLE);
	assign accept_in = s_tvalid & s_tready;
	assign complete  = (st_q == ST_EXEC) & (~out_valid_q | m_tready);
	assign in_row    = s_tdata[7 +: nfa_wr_pkg::LETTER_W];
	assign cur_row   = letter_s1[nfa_wr_pkg::LETTER_W-1:0];

	// read the letter's row on acceptance; hold it through a stall
	always_ff @(posedge clk) begin
		if (accept_in) begin
			req_s1       <= s_tdata[1:0];
			from_s1      <= s_tdata[6:2];
			letter_s1    <= s_tdata[14:7];
			to_s1        <= s_tdata[19:15];
			rdata_s1     <= mem[in_row];
			row_valid_s1 <= row_valid_q[in_row];
		end
		if (complete && req_s1 == nfa_wr_pkg::REQ_ADD && add_ok) begin
			mem[cur_row] <= row_new;
		end
	end

	always_comb begin
		letter_ok = int'(letter_s1) < nfa_wr_pkg::LETTER_COUNT;
		add_ok    = letter_ok && int'(from_s1) < nfa_wr_pkg::NUM_STATES
			&& int'(to_s1) < nfa_wr_pkg::NUM_STATES;
		row_cur   = row_valid_s1 ? rdata_s1 : '0;
		bit_idx   = nfa_wr_pkg::ROW_IDX_W'(int'(from_s1) * nfa_wr_pkg::NUM_STATES
			+ int'(to_s1));
		row_new   = row_cur;
		row_new[bit_idx] = 1'b1;
		succ      = '0;
		for (int s = 0; s < nfa_wr_pkg::NUM_STATES; s++) begin
			if (active_q[s]) begin
				succ = succ | row_cur[s*nfa_wr_pkg::NUM_STATES +: nfa_wr_pkg::NUM_STATES];
			end
		end
		case (req_s1)
			nfa_wr_pkg::REQ_START:  active_next = initial_q;
			nfa_wr_pkg::REQ_SYMBOL: active_next = letter_ok ? succ : '0;
			default:                active_next = active_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			active_q    <= '0;
			row_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept_in) begin
						st_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (complete) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (complete) begin
				active_q    <= active_next;
				out_valid_q <= 1'b1;
				if (req_s1 == nfa_wr_pkg::REQ_ADD && add_ok) begin
					row_valid_q[cur_row] <= 1'b1;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			out_set_q <= active_next;
			out_acc_q <= |(active_next & final_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(nfa_wr_pkg::OUT_W - nfa_wr_pkg::NUM_STATES - 1){1'b0}},
		out_acc_q, out_set_q};

	// one request in flight: no second acceptance right after the first
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept_in |=> !s_tready)
		else $error("request accepted while another is executing");

	// a result is only produced when the output register is free to take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !complete)
		else $error("result overwrote a stalled word");

	// the active set after each request is the one reported
	a_set_reported: assert property (@(posedge clk) disable iff (!arst_n)
		complete |=> (m_tvalid && m_tdata[nfa_wr_pkg::NUM_STATES-1:0] == active_q))
		else $error("reported set differs from active set");

endmodule

`default_nettype wire

// File: dv/nfa_wr_checker.sv
// Result checker for the NFA word recognizer: tracks the APB register writes and the
// request stream, predicts each result word and compares it with the result stream.
// Depends on nfa_wr_pkg.
`default_nettype none

module nfa_wr_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [nfa_wr_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                    pwdata,
	input  wire logic                           pready,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	// s_tdata: req_type[1:0], from_state[6:2], letter[14:7], to_state[19:15], zero pad
	input  wire logic [nfa_wr_pkg::IN_W-1:0]    s_tdata,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	// m_tdata: active_set[31:0], accepted[32], zero pad
	input  wire logic [nfa_wr_pkg::OUT_W-1:0]   m_tdata,
	output int                                  fail_count,
	output int                                  pending
);

	localparam int SUCC_IDX_W = $clog2(nfa_wr_pkg::NUM_STATES * nfa_wr_pkg::LETTER_COUNT);

	typedef struct packed {
		logic                   accepted;
		nfa_wr_pkg::state_set_t active_set;
	} set_report_t;

	nfa_wr_pkg::state_set_t succ_masks [nfa_wr_pkg::NUM_STATES*nfa_wr_pkg::LETTER_COUNT];
	nfa_wr_pkg::state_set_t live_set;
	nfa_wr_pkg::state_set_t initial_reg;
	nfa_wr_pkg::state_set_t final_reg;
	set_report_t            predicted_reports [$];

	function automatic nfa_wr_pkg::state_set_t advance_set(
		input nfa_wr_pkg::state_set_t cur, input logic [7:0] sym);
		nfa_wr_pkg::state_set_t nxt;
		nxt = '0;
		for (int s = 0; s < nfa_wr_pkg::NUM_STATES; s++)
			if (cur[s])
				nxt |= succ_masks[SUCC_IDX_W'(int'(sym) * nfa_wr_pkg::NUM_STATES + s)];
		return nxt;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		set_report_t            want;
		logic [1:0]             req;
		logic [4:0]             src;
		logic [4:0]             dst;
		logic [7:0]             sym;
		logic                   got_acc;
		nfa_wr_pkg::state_set_t got_set;
		if (!arst_n) begin
			foreach (succ_masks[i])
				succ_masks[i] = '0;
			live_set = '0;
			initial_reg = '0;
			final_reg = '0;
			predicted_reports.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				req = s_tdata[1:0];
				src = s_tdata[6:2];
				sym = s_tdata[14:7];
				dst = s_tdata[19:15];
				case (req)
					nfa_wr_pkg::REQ_ADD:
						succ_masks[SUCC_IDX_W'(int'(sym) * nfa_wr_pkg::NUM_STATES
							+ int'(src))][dst] = 1'b1;
					nfa_wr_pkg::REQ_START:  live_set = initial_reg;
					nfa_wr_pkg::REQ_SYMBOL: live_set = advance_set(live_set, sym);
					default: ;
				endcase
				want.active_set = live_set;
				want.accepted = |(live_set & final_reg);
				predicted_reports.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got_set = m_tdata[31:0];
				got_acc = m_tdata[32];
				if (predicted_reports.size() == 0) begin
					$display("%0t: unexpected result word, active_set %h accepted %b",
						$time, got_set, got_acc);
					fail_count++;
				end else begin
					want = predicted_reports.pop_front();
					if (got_set !== want.active_set) begin
						$display("%0t: active_set mismatch, expected %h actual %h",
							$time, want.active_set, got_set);
						fail_count++;
					end
					if (got_acc !== want.accepted) begin
						$display("%0t: accepted mismatch, expected %b actual %b",
							$time, want.accepted, got_acc);
						fail_count++;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[nfa_wr_pkg::ADDR_W-1:2] == nfa_wr_pkg::REG_FINAL)
					final_reg = pwdata;
				else
					initial_reg = pwdata;
			end
			pending <= predicted_reports.size();
		end
	end

endmodule

`default_nettype wire

// File: dv/tb_nfa_word_recognizer_top.sv
// Testbench top for nfa_word_recognizer_top: directed and random request words,
// APB register settings and random stalls on both streams; nfa_wr_checker judges results.
// Depends on nfa_wr_pkg, nfa_word_recognizer_top and nfa_wr_checker.
`default_nettype none

module tb_nfa_word_recognizer_top;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [nfa_wr_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [nfa_wr_pkg::IN_W-1:0]   s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [nfa_wr_pkg::OUT_W-1:0]  m_tdata;
	logic                          steady = 1'b0;
	int                            fail_count;
	int                            pending;
	logic [7:0]                    hot_letters [4];

	nfa_word_recognizer_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	nfa_wr_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 32);
	end

	task automatic reg_write(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Leaves tvalid high after acceptance so back-to-back words need no toggle.
	task automatic send_word(input logic [1:0] req, input logic [4:0] src,
		input logic [7:0] sym, input logic [4:0] dst);
		while (!steady && $urandom_range(0, 99) < 32) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(nfa_wr_pkg::IN_W-20){1'b0}}, dst, sym, src, req};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Hold off the sender until every result word is back.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_masks(input logic [31:0] init_mask, input logic [31:0] final_mask);
		drain();
		reg_write(nfa_wr_pkg::REG_INITIAL, init_mask);
		reg_write(nfa_wr_pkg::REG_FINAL, final_mask);
	endtask

	// Mostly well-formed words over a few hot letters, plus transition adds and noise.
	task automatic random_phase(input int n_items);
		int         sent;
		int         roll;
		int         len;
		logic [7:0] sym;
		sent = 0;
		foreach (hot_letters[i])
			hot_letters[i] = 8'($urandom_range(0, 255));
		while (sent < n_items) begin
			roll = $urandom_range(0, 99);
			if (roll < 25) begin
				sym = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
					: hot_letters[2'($urandom_range(0, 3))];
				send_word(nfa_wr_pkg::REQ_ADD, 5'($urandom_range(0, 31)), sym,
					5'($urandom_range(0, 31)));
				sent++;
			end else if (roll < 85) begin
				len = $urandom_range(1, 8);
				send_word(nfa_wr_pkg::REQ_START, 5'($urandom_range(0, 31)),
					8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
				for (int k = 0; k < len; k++)
					send_word(nfa_wr_pkg::REQ_SYMBOL, 5'($urandom_range(0, 31)),
						hot_letters[2'($urandom_range(0, 3))], 5'($urandom_range(0, 31)));
				sent += len + 1;
			end else begin
				send_word(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
					8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_masks(32'h0000_0003, 32'h8000_0001);
		// symbol with nothing active and no transitions stored
		send_word(nfa_wr_pkg::REQ_SYMBOL, 5'd0, 8'd0, 5'd0);
		// empty word: initial state 0 is final
		send_word(nfa_wr_pkg::REQ_START, 5'd0, 8'd0, 5'd0);
		send_word(nfa_wr_pkg::REQ_ADD, 5'd0, 8'd0, 5'd31);
		send_word(nfa_wr_pkg::REQ_ADD, 5'd1, 8'd0, 5'd1);
		send_word(nfa_wr_pkg::REQ_ADD, 5'd0, 8'd0, 5'd31);
		send_word(nfa_wr_pkg::REQ_ADD, 5'd31, 8'd255, 5'd0);
		send_word(nfa_wr_pkg::REQ_ADD, 5'd31, 8'd255, 5'd31);
		send_word(nfa_wr_pkg::REQ_ADD, 5'd10, 8'h55, 5'd21);
		send_word(nfa_wr_pkg::REQ_ADD, 5'd21, 8'hAA, 5'd10);
		send_word(nfa_wr_pkg::REQ_SYMBOL, 5'd31, 8'd0, 5'd31);
		send_word(nfa_wr_pkg::REQ_SYMBOL, 5'd0, 8'd255, 5'd0);
		// unused request type reports the set unchanged
		send_word(2'd3, 5'd31, 8'd255, 5'd31);
		// letter with no stored transitions empties the set
		send_word(nfa_wr_pkg::REQ_SYMBOL, 5'd0, 8'h5A, 5'd0);
		send_word(nfa_wr_pkg::REQ_SYMBOL, 5'd0, 8'd0, 5'd0);
		send_word(nfa_wr_pkg::REQ_START, 5'd31, 8'd255, 5'd31);
		send_word(nfa_wr_pkg::REQ_SYMBOL, 5'd0, 8'd255, 5'd0);

		set_masks(32'hFFFF_FFFF, 32'h0000_0000);
		send_word(nfa_wr_pkg::REQ_START, 5'd0, 8'd0, 5'd0);
		send_word(nfa_wr_pkg::REQ_SYMBOL, 5'd0, 8'h55, 5'd0);
		send_word(nfa_wr_pkg::REQ_SYMBOL, 5'd0, 8'hAA, 5'd0);
		send_word(nfa_wr_pkg::REQ_SYMBOL, 5'd0, 8'h55, 5'd0);

		set_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_phase(240);
		set_masks(32'h0000_0000, 32'h0000_0000);
		random_phase(240);
		set_masks($urandom(), $urandom());
		steady <= 1'b1;
		random_phase(240);
		drain();
		steady <= 1'b0;
		set_masks(32'h0000_0001, 32'h8000_0000);
		random_phase(240);
		set_masks($urandom(), $urandom());
		random_phase(240);
		set_masks(32'h8000_0000, 32'h0000_0001);
		random_phase(240);

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
